// ----- src/tbf_pkg.sv -----
package tbf_pkg;

   // Width of the number and totient ports
   localparam int FIELD_WIDTH = 32;

   // Default internal arithmetic width
   localparam int NUMBER_WIDTH_DEFAULT = 32;

endpackage

// ----- src/tbf_div.sv -----
module tbf_div #(
   parameter int NUMBER_WIDTH = tbf_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [NUMBER_WIDTH-1:0] divisor,
   output logic                    done,
   output logic [NUMBER_WIDTH-1:0] quotient,
   output logic [NUMBER_WIDTH-1:0] remainder
);
   import tbf_pkg::*;

   localparam int CountW = $clog2(NUMBER_WIDTH + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CountW-1:0]       count_ff, count_in;
   logic [NUMBER_WIDTH-1:0] quo_ff, quo_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] dsr_ff, dsr_in;
   logic [NUMBER_WIDTH:0]   rem_shift;
   logic [NUMBER_WIDTH:0]   rem_diff;
   logic                    fits;

   // Shift in one dividend bit and try a subtract
   assign rem_shift = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
   assign fits      = (rem_shift >= {1'b0, dsr_ff});
   assign rem_diff  = rem_shift - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (go) begin
         // Load operands, one quotient bit per cycle follows
         busy_in  = 1'b1;
         count_in = CountW'(NUMBER_WIDTH);
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[NUMBER_WIDTH-2:0], fits};
         rem_in   = fits ? rem_diff[NUMBER_WIDTH-1:0] : rem_shift[NUMBER_WIDTH-1:0];
         count_in = count_ff - CountW'(1);
         if (count_ff == CountW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/totient_by_factorization.sv -----
// Euler totient phi(n) of an unsigned number by trial division. Raise start while busy is low
// to launch a transaction; busy stays high until the result, which appears on rsp_totient for
// exactly one cycle with rsp_strobe high and cannot be stalled, so capture it then. Zero is
// answered on the next cycle without raising busy. The run time is set by one shared restoring
// divider (one trial division per odd candidate divisor, repeated divisions by a found prime
// included) plus a shift-add multiplier, run for each prime factor divided out and for a
// leftover prime cofactor, plus the shifts that drop factors of two. Worst case for 32-bit n
// tries about 32768 odd divisors; small or smooth numbers finish far sooner. phi(0) is 0 and
// phi(1) is 1.
module totient_by_factorization #(
   parameter int NUMBER_WIDTH = tbf_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tbf_pkg::FIELD_WIDTH-1:0] req_number,
   output logic                         rsp_strobe,
   output logic [tbf_pkg::FIELD_WIDTH-1:0] rsp_totient
);
   import tbf_pkg::*;

   localparam int WideW = (NUMBER_WIDTH > FIELD_WIDTH) ? NUMBER_WIDTH : FIELD_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TWOS,
      ST_DIV,
      ST_WAIT,
      ST_TAIL,
      ST_MUL
   } state_type;

   state_type               state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] rest_ff, rest_in;
   logic [NUMBER_WIDTH-1:0] phi_ff, phi_in;
   logic [NUMBER_WIDTH-1:0] dvs_ff, dvs_in;
   logic                    again_ff, again_in;
   logic                    last_ff, last_in;
   logic [NUMBER_WIDTH-1:0] acc_ff, acc_in;
   logic [NUMBER_WIDTH-1:0] mula_ff, mula_in;
   logic [NUMBER_WIDTH-1:0] mulb_ff, mulb_in;
   logic                    strobe_ff, strobe_in;
   logic [FIELD_WIDTH-1:0]  totient_ff, totient_in;

   logic [WideW-1:0]        num_wide;
   logic [NUMBER_WIDTH-1:0] num;
   logic [WideW-1:0]        phi_wide;
   logic [WideW-1:0]        acc_wide;
   logic                    div_go;
   logic                    div_done;
   logic [NUMBER_WIDTH-1:0] div_quo;
   logic [NUMBER_WIDTH-1:0] div_rem;

   // Fit the port value to the internal width and back
   assign num_wide = WideW'(req_number);
   assign num      = num_wide[NUMBER_WIDTH-1:0];
   assign phi_wide = WideW'(phi_ff);
   assign acc_wide = WideW'(acc_ff);

   assign div_go = (state_ff == ST_DIV);

   tbf_div #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (rest_ff),
      .divisor  (dvs_ff),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   always_comb begin
      state_in   = state_ff;
      rest_in    = rest_ff;
      phi_in     = phi_ff;
      dvs_in     = dvs_ff;
      again_in   = again_ff;
      last_in    = last_ff;
      acc_in     = acc_ff;
      mula_in    = mula_ff;
      mulb_in    = mulb_ff;
      strobe_in  = 1'b0;
      totient_in = totient_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               phi_in   = NUMBER_WIDTH'(1);
               dvs_in   = NUMBER_WIDTH'(3);
               again_in = 1'b0;
               if (num == '0) begin
                  // Zero has no totient to search for
                  strobe_in  = 1'b1;
                  totient_in = '0;
               end else if (!num[0]) begin
                  rest_in  = num >> 1;
                  state_in = ST_TWOS;
               end else begin
                  rest_in  = num;
                  state_in = ST_DIV;
               end
            end
         end
         ST_TWOS: begin
            // Drop further factors of two, doubling phi for each
            if (!rest_ff[0]) begin
               rest_in = rest_ff >> 1;
               phi_in  = phi_ff << 1;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               if (!again_ff && (div_quo < dvs_ff)) begin
                  // Divisor passed the square root of the cofactor
                  state_in = ST_TAIL;
               end else if (div_rem == '0) begin
                  rest_in  = div_quo;
                  mula_in  = phi_ff;
                  mulb_in  = again_ff ? dvs_ff : (dvs_ff - NUMBER_WIDTH'(1));
                  acc_in   = '0;
                  again_in = 1'b1;
                  last_in  = 1'b0;
                  state_in = ST_MUL;
               end else begin
                  dvs_in   = dvs_ff + NUMBER_WIDTH'(2);
                  again_in = 1'b0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_TAIL: begin
            // Fold in a leftover prime cofactor
            if (rest_ff > NUMBER_WIDTH'(1)) begin
               mula_in  = phi_ff;
               mulb_in  = rest_ff - NUMBER_WIDTH'(1);
               acc_in   = '0;
               last_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               strobe_in  = 1'b1;
               totient_in = phi_wide[FIELD_WIDTH-1:0];
               state_in   = ST_IDLE;
            end
         end
         ST_MUL: begin
            // Shift-add multiply, one multiplier bit per cycle
            if (mulb_ff == '0) begin
               phi_in = acc_ff;
               if (last_ff) begin
                  strobe_in  = 1'b1;
                  totient_in = acc_wide[FIELD_WIDTH-1:0];
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_DIV;
               end
            end else begin
               if (mulb_ff[0]) begin
                  acc_in = acc_ff + mula_ff;
               end
               mula_in = mula_ff << 1;
               mulb_in = mulb_ff >> 1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      rest_ff    <= rest_in;
      phi_ff     <= phi_in;
      dvs_ff     <= dvs_in;
      again_ff   <= again_in;
      last_ff    <= last_in;
      acc_ff     <= acc_in;
      mula_ff    <= mula_in;
      mulb_ff    <= mulb_in;
      totient_ff <= totient_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_totient = totient_ff;

endmodule
